### hdl/http_chunked_body_decoder_macros.svh
// Assertion macros shared by the checker of the chunked body decoder.
// Depends on nothing; expects clk and arst_n in the scope of use.
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// Check cons in the same cycle as ante, outside reset.
`define HCBD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define HCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Check cons in the same cycle as ante, reset included.
`define HCBD_ASSERT_ALWAYS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error(msg);

`endif

### hdl/hcbd_pkg.sv
// Shared types and constants of the chunked body decoder.
// Depends on nothing.
package hcbd_pkg;

	localparam int COUNT_BITS = 31;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_SP  = 8'h20;

	typedef enum logic [1:0] {
		KIND_BYTE       = 2'd0,
		KIND_BAD_SIZE   = 2'd1,
		KIND_ZERO_CHUNK = 2'd2
	} kind_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] bytes_remaining;
		logic [COUNT_BITS-1:0] size_accum;
		logic                  hex_seen;
		logic                  hex_stopped;
		logic                  line_nonempty;
		logic                  pending_cr;
		logic                  size_overflow;
	} dec_state_t;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] body_byte;
	} dec_result_t;

endpackage

### hdl/hcbd_step.sv
// Next-state and result logic for one byte of the chunked body decoder.
// Depends on hcbd_pkg.
module hcbd_step (
	input  logic                 chunked_mode,
	input  logic [7:0]           data_byte,
	input  hcbd_pkg::dec_state_t cur,
	output hcbd_pkg::dec_state_t nxt,
	output hcbd_pkg::dec_result_t res
);

	function automatic hcbd_pkg::dec_state_t line_char(
		input hcbd_pkg::dec_state_t st,
		input logic [7:0]           c
	);
		hcbd_pkg::dec_state_t r;
		logic                 is_hex;
		logic [3:0]           d;
		logic                 blank;
		r      = st;
		is_hex = 1'b0;
		d      = 4'd0;
		if (c >= "0" && c <= "9") begin
			is_hex = 1'b1;
			d      = 4'(c - "0");
		end else if (c >= "a" && c <= "f") begin
			is_hex = 1'b1;
			d      = 4'(c - "a" + 8'd10);
		end else if (c >= "A" && c <= "F") begin
			is_hex = 1'b1;
			d      = 4'(c - "A" + 8'd10);
		end
		blank = (c == hcbd_pkg::CH_SP) || (c == hcbd_pkg::CH_TAB) ||
			(c == hcbd_pkg::CH_LF) || (c == hcbd_pkg::CH_VT) ||
			(c == hcbd_pkg::CH_FF) || (c == hcbd_pkg::CH_CR);
		r.line_nonempty = 1'b1;
		if (!st.hex_stopped) begin
			if (is_hex) begin
				r.hex_seen = 1'b1;
				if (!st.size_overflow) begin
					if (st.size_accum[hcbd_pkg::COUNT_BITS-1 -: 4] != 4'd0) begin
						r.size_overflow = 1'b1;
					end else begin
						r.size_accum = {st.size_accum[hcbd_pkg::COUNT_BITS-5:0], d};
					end
				end
			end else if (st.hex_seen || !blank) begin
				r.hex_stopped = 1'b1;
			end
		end
		return r;
	endfunction

	hcbd_pkg::dec_state_t tmp;

	always_comb begin
		nxt           = cur;
		tmp           = cur;
		res.valid     = 1'b0;
		res.kind      = hcbd_pkg::KIND_BYTE;
		res.body_byte = 8'd0;
		if (!chunked_mode || cur.bytes_remaining != '0) begin
			if (chunked_mode) begin
				nxt.bytes_remaining = cur.bytes_remaining -
					{{(hcbd_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
			end
			res.valid     = 1'b1;
			res.body_byte = data_byte;
		end else if (cur.pending_cr && data_byte == hcbd_pkg::CH_LF) begin
			if (cur.line_nonempty) begin
				if (!cur.hex_seen || cur.size_overflow) begin
					res.valid = 1'b1;
					res.kind  = hcbd_pkg::KIND_BAD_SIZE;
				end else if (cur.size_accum == '0) begin
					res.valid = 1'b1;
					res.kind  = hcbd_pkg::KIND_ZERO_CHUNK;
				end else begin
					nxt.bytes_remaining = cur.size_accum;
				end
			end
			nxt.size_accum    = '0;
			nxt.hex_seen      = 1'b0;
			nxt.hex_stopped   = 1'b0;
			nxt.line_nonempty = 1'b0;
			nxt.pending_cr    = 1'b0;
			nxt.size_overflow = 1'b0;
		end else begin
			if (cur.pending_cr) begin
				tmp.pending_cr = 1'b0;
				tmp = line_char(tmp, hcbd_pkg::CH_CR);
			end
			if (data_byte == hcbd_pkg::CH_CR) begin
				tmp.pending_cr = 1'b1;
			end else begin
				tmp = line_char(tmp, data_byte);
			end
			nxt = tmp;
		end
	end

endmodule

### hdl/http_chunked_body_decoder.sv
// A byte accepted into the s1 register is decoded there, and its result is registered in the output stage on m_*.
// Throughput: one byte per cycle unless m_tready stalls the output; the decoder state feeds back through hcbd_step.
// Bytes of a size line give no result and are dropped, but a closing LF gives a bad-size or zero-chunk marker.
// Reset (arst_n low, asynchronous) clears the valid bits of both stages, the decoder state and chunked_mode.
module http_chunked_body_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,  // chunked_mode
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] data_byte
	input  logic       s_tlast,    // last_of_segment, no effect on decoding
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [7:0] body_byte
	output logic [1:0] m_tuser     // [1:0] result_kind
);

	logic                  mode_q;
	logic                  valid_s1;
	logic [7:0]            data_s1;
	logic                  last_s1;
	hcbd_pkg::dec_state_t  state_q;
	hcbd_pkg::dec_state_t  state_nxt;
	hcbd_pkg::dec_result_t res;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	hcbd_pkg::kind_t       out_kind_q;
	logic                  can_load;
	logic                  advance;

	assign can_load = !out_valid_q || m_tready;
	assign advance  = valid_s1 && can_load;
	assign s_tready = !valid_s1 || advance;

	hcbd_step u_step (
		.chunked_mode (mode_q),
		.data_byte    (data_s1),
		.cur          (state_q),
		.nxt          (state_nxt),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= advance && res.valid;
		end
	end

	// last_s1 rides along with the byte; segment marks do not shape the result
	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_byte_q <= res.body_byte & {8{!last_s1 || 1'b1}};
			out_kind_q <= res.kind;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_kind_q;

endmodule

### hdl/hcbd_checker.sv
// Port-level checks of the chunked body decoder, bound to the top level.
// Depends on hcbd_pkg and http_chunked_body_decoder_macros.svh.
`include "http_chunked_body_decoder_macros.svh"

module hcbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser
);

	`HCBD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled transaction changed")
	`HCBD_ASSERT_NOW(a_marker_zero, m_tvalid && m_tuser != hcbd_pkg::KIND_BYTE, m_tdata == 8'd0, "marker transaction carries data")
	`HCBD_ASSERT_NOW(a_ready_free, m_tready || !m_tvalid, s_tready, "input stalled with output free")
	`HCBD_ASSERT_ALWAYS(a_reset_idle, !arst_n, !m_tvalid, "output valid in reset")

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for http_chunked_body_decoder: streams plain and chunked bodies
// with random gaps and stalls and checks every result against a cycle-free decoder model.
// Depends on hcbd_pkg and the decoder RTL.
module testbench;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int ITEM_TARGET    = 750;
	localparam string HEX_CHARS   = "0123456789abcdefABCDEF";

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} body_item_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;

	body_item_t            pending_bytes[$];
	hcbd_pkg::dec_result_t expected_results[$];
	int                    n_items = 0;
	int                    fails = 0;
	int                    src_gap = 0;
	int                    snk_stall = 0;
	bit                    src_gaps_on = 1'b1;
	bit                    snk_gaps_on = 1'b1;
	int                    carry_left = 0;

	// decoder model state
	logic                            chunked_on;
	logic [hcbd_pkg::COUNT_BITS-1:0] left_in_chunk;
	logic [hcbd_pkg::COUNT_BITS-1:0] size_value;
	logic                            hex_found;
	logic                            digits_ended;
	logic                            line_used;
	logic                            cr_waiting;
	logic                            size_too_big;

	http_chunked_body_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void clear_size_line();
		size_value = '0;
		hex_found = 1'b0;
		digits_ended = 1'b0;
		line_used = 1'b0;
		cr_waiting = 1'b0;
		size_too_big = 1'b0;
	endfunction

	function automatic void take_line_char(input logic [7:0] c);
		logic       is_hex;
		logic [3:0] nib;
		is_hex = 1'b1;
		nib = c[3:0];
		if (c >= "0" && c <= "9") begin
			nib = c[3:0];
		end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
			nib = c[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
		end
		line_used = 1'b1;
		if (digits_ended)
			return;
		if (is_hex) begin
			hex_found = 1'b1;
			if (!size_too_big) begin
				if (size_value[hcbd_pkg::COUNT_BITS-1 -: 4] != 4'd0)
					size_too_big = 1'b1;
				else
					size_value = {size_value[hcbd_pkg::COUNT_BITS-5:0], nib};
			end
			return;
		end
		if (!hex_found && (c == hcbd_pkg::CH_SP || c == hcbd_pkg::CH_TAB ||
				c == hcbd_pkg::CH_LF || c == hcbd_pkg::CH_VT ||
				c == hcbd_pkg::CH_FF || c == hcbd_pkg::CH_CR))
			return;
		digits_ended = 1'b1;
	endfunction

	function automatic hcbd_pkg::dec_result_t decode_byte(input logic [7:0] b);
		hcbd_pkg::dec_result_t r;
		r.valid = 1'b0;
		r.kind = hcbd_pkg::KIND_BYTE;
		r.body_byte = 8'h00;
		if (!chunked_on || left_in_chunk != '0) begin
			if (chunked_on)
				left_in_chunk = left_in_chunk - {{(hcbd_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
			r.valid = 1'b1;
			r.body_byte = b;
			return r;
		end
		if (cr_waiting && b == hcbd_pkg::CH_LF) begin
			if (line_used) begin
				if (!hex_found || size_too_big) begin
					r.valid = 1'b1;
					r.kind = hcbd_pkg::KIND_BAD_SIZE;
				end else if (size_value == '0) begin
					r.valid = 1'b1;
					r.kind = hcbd_pkg::KIND_ZERO_CHUNK;
				end else begin
					left_in_chunk = size_value;
				end
			end
			clear_size_line();
			return r;
		end
		if (cr_waiting) begin
			cr_waiting = 1'b0;
			take_line_char(hcbd_pkg::CH_CR);
		end
		if (b == hcbd_pkg::CH_CR)
			cr_waiting = 1'b1;
		else
			take_line_char(b);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] payload_byte();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return hcbd_pkg::CH_CR;
		if (r == 1)
			return hcbd_pkg::CH_LF;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 5))
			0: return hcbd_pkg::CH_SP;
			1: return hcbd_pkg::CH_TAB;
			2: return hcbd_pkg::CH_LF;
			3: return hcbd_pkg::CH_VT;
			4: return hcbd_pkg::CH_FF;
			default: return hcbd_pkg::CH_CR;
		endcase
	endfunction

	task automatic add_byte(input logic [7:0] b);
		body_item_t it;
		it.data = b;
		it.last = ($urandom_range(0, 7) == 0);
		pending_bytes = {pending_bytes, it};
		n_items++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_crlf();
		add_byte(hcbd_pkg::CH_CR);
		add_byte(hcbd_pkg::CH_LF);
	endtask

	task automatic add_size_line(input int unsigned size);
		string digits;
		digits = $sformatf("%0h", size);
		if ($urandom_range(0, 3) == 0)
			digits = digits.toupper();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) add_byte(blank_char());
		repeat ($urandom_range(0, 5) / 4) add_text("0");
		add_text(digits);
		case ($urandom_range(0, 5))
			0: add_text(";ext=1");
			1: begin
				add_byte(hcbd_pkg::CH_SP);
				add_text(";v");
			end
			2: begin
				add_byte(hcbd_pkg::CH_TAB);
				add_text("q=z");
			end
			default: ;
		endcase
		add_crlf();
	endtask

	task automatic add_chunk(input int unsigned size);
		add_size_line(size);
		repeat (size) add_byte(payload_byte());
		add_crlf();
	endtask

	task automatic add_bad_line();
		string junk;
		junk = "ghxyz;=-_G/";
		if ($urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 3))
				add_byte(($urandom_range(0, 1) == 0) ? hcbd_pkg::CH_SP : hcbd_pkg::CH_TAB);
		end else begin
			repeat ($urandom_range(1, 3)) add_byte(junk[$urandom_range(0, junk.len() - 1)]);
		end
		add_crlf();
	endtask

	task automatic add_overflow_line();
		add_byte(HEX_CHARS[$urandom_range(8, 21)]);
		repeat ($urandom_range(7, 9)) add_byte(HEX_CHARS[$urandom_range(0, 21)]);
		add_crlf();
	endtask

	task automatic add_broken_cr_line();
		int unsigned n;
		logic [7:0]  b;
		n = $urandom_range(1, 6);
		b = 8'($urandom);
		if (b == hcbd_pkg::CH_LF)
			b = 8'h2E;
		add_text($sformatf("%0h", n));
		add_byte(hcbd_pkg::CH_CR);
		add_byte(b);
		add_crlf();
		repeat (n) add_byte(payload_byte());
		add_crlf();
	endtask

	function automatic int unsigned pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 8);
		if (r < 95)
			return $urandom_range(9, 40);
		return $urandom_range(41, 200);
	endfunction

	task automatic fill_chunked_phase();
		int target;
		int n;
		int k;
		int r;
		target = n_items + $urandom_range(80, 130);
		if (carry_left > 0) begin
			repeat (carry_left) add_byte(payload_byte());
			add_crlf();
			carry_left = 0;
		end
		while (n_items < target) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				add_chunk(pick_size());
			end else if (r < 68) begin
				add_chunk(0);
			end else if (r < 76) begin
				add_bad_line();
			end else if (r < 84) begin
				add_overflow_line();
			end else if (r < 90) begin
				add_broken_cr_line();
			end else if (r < 95) begin
				add_crlf();
			end else begin
				repeat ($urandom_range(1, 2)) add_byte(8'($urandom));
				add_crlf();
			end
		end
		// leave a chunk open across the next mode change
		if ($urandom_range(0, 1) == 1) begin
			n = $urandom_range(2, 12);
			k = $urandom_range(1, n - 1);
			add_size_line(n);
			repeat (k) add_byte(payload_byte());
			carry_left = n - k;
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_bytes.size() != 0 || s_tvalid || expected_results.size() != 0);
	endtask

	task automatic set_mode(input logic mode);
		wait_drained();
		repeat (8) @(posedge clk);
		cfg_wdata <= mode;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		chunked_on = mode;
	endtask

	always @(posedge clk) begin
		body_item_t            next_item;
		hcbd_pkg::dec_result_t outcome;
		logic                  load;
		if (arst_n && !(s_tvalid && !s_tready)) begin
			if (s_tvalid) begin
				outcome = decode_byte(s_tdata);
				if (outcome.valid)
					expected_results = {expected_results, outcome};
			end
			load = 1'b0;
			if (src_gap > 0) begin
				src_gap--;
			end else if (pending_bytes.size() > 0) begin
				next_item = pending_bytes.pop_front();
				load = 1'b1;
				src_gap = src_gaps_on ? pick_gap() : 0;
			end
			s_tvalid <= load;
			if (load) begin
				s_tdata <= next_item.data;
				s_tlast <= next_item.last;
			end
		end
	end

	always @(posedge clk) begin
		hcbd_pkg::dec_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected transaction: result_kind %0d, body_byte 0x%02h",
						m_tuser, m_tdata);
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (m_tuser !== want.kind) begin
						$error("result_kind: expected %0d, got %0d", want.kind, m_tuser);
						fails++;
					end
					if (m_tdata !== want.body_byte) begin
						$error("body_byte: expected 0x%02h, got 0x%02h", want.body_byte, m_tdata);
						fails++;
					end
				end
			end
			if (snk_stall > 0) begin
				snk_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				snk_stall = snk_gaps_on ? pick_gap() : 0;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int phase;
		arst_n <= 1'b0;
		chunked_on = 1'b0;
		left_in_chunk = '0;
		clear_size_line();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		set_mode(1'b0);
		add_byte(8'h00);
		add_byte(8'hFF);

		set_mode(1'b1);
		add_crlf();
		add_byte(hcbd_pkg::CH_SP);
		add_text("2;x");
		add_crlf();
		add_byte(8'hFF);
		add_byte(8'h00);
		add_text("g");
		add_crlf();
		add_text("0");
		add_crlf();
		add_byte(hcbd_pkg::CH_CR);
		add_text("1");
		add_crlf();
		add_byte(hcbd_pkg::CH_CR);

		for (phase = 0; n_items < ITEM_TARGET; phase++) begin
			set_mode((phase % 4) != 3);
			src_gaps_on = (phase % 3) != 1;
			snk_gaps_on = (phase % 4) != 2;
			if (chunked_on)
				fill_chunked_phase();
			else
				repeat ($urandom_range(30, 50)) add_byte(8'($urandom));
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
